>>> hw/rtl/bdss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bdss_pkg;

   // Name storage: a symbol keeps at most BUF_CAP bytes, each name slot holds 32.
   localparam int NAME_MAX   = 32;
   localparam int BUF_CAP    = (NAME_MAX < 32) ? NAME_MAX : 32;
   localparam int IDX_W      = 5;
   localparam int LEN_W      = 6;
   localparam int MEM_AW     = IDX_W + 1;
   localparam int MEM_DEPTH  = 2 ** MEM_AW;

   // The line counter saturates at its all-ones value; the port shows 24 bits.
   localparam int LINE_BITS  = 24;
   localparam int LINE_OUT_W = 24;

   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_NL      = 8'h0A;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_HASH    = 8'h23;
   localparam logic [7:0] CH_DOLLAR  = 8'h24;
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_QUOTE   = 8'h27;
   localparam logic [7:0] CH_LPAREN  = 8'h28;
   localparam logic [7:0] CH_RPAREN  = 8'h29;
   localparam logic [7:0] CH_COMMA   = 8'h2C;
   localparam logic [7:0] CH_DOT     = 8'h2E;
   localparam logic [7:0] CH_LBRACK  = 8'h5B;
   localparam logic [7:0] CH_RBRACK  = 8'h5D;

   // Keywords, lower case, left justified in eight bytes.
   localparam logic [63:0] KW_FUNCTION = "function";
   localparam logic [63:0] KW_TYPE     = {"type", 32'h0};
   localparam logic [63:0] KW_GLOBAL   = {"global", 16'h0};
   localparam logic [63:0] KW_CONST    = {"const", 24'h0};

   typedef enum logic [2:0] {
      KIND_LABEL    = 3'd0,
      KIND_FUNCTION = 3'd1,
      KIND_TYPE     = 3'd2,
      KIND_GLOBAL   = 3'd3,
      KIND_CONST    = 3'd4
   } kind_type;

   typedef struct packed {
      kind_type                kind;
      logic [LINE_OUT_W-1:0]   line;
      logic [LEN_W-1:0]        length;
      logic                    truncated;
      logic                    slot;
   } sym_desc_type;

   typedef struct packed {
      logic                en;
      logic [MEM_AW-1:0]   addr;
      logic [7:0]          data;
   } name_wr_type;

   function automatic logic is_start(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

   function automatic logic is_ident(input logic [7:0] c);
      return is_start(c) || (c >= "0" && c <= "9") || c == CH_DOLLAR ||
             c == CH_HASH || c == CH_PERCENT;
   endfunction

   function automatic logic [7:0] to_lower(input logic [7:0] c);
      return (c >= "A" && c <= "Z") ? c + 8'h20 : c;
   endfunction

   function automatic logic [3:0] kw_len(input kind_type id);
      logic [3:0] n;
      unique case (id)
         KIND_FUNCTION: n = 4'd8;
         KIND_TYPE:     n = 4'd4;
         KIND_GLOBAL:   n = 4'd6;
         KIND_CONST:    n = 4'd5;
         default:       n = 4'd0;
      endcase
      return n;
   endfunction

   function automatic logic [7:0] kw_char(input kind_type id, input logic [2:0] pos);
      logic [63:0] w;
      unique case (id)
         KIND_FUNCTION: w = KW_FUNCTION;
         KIND_TYPE:     w = KW_TYPE;
         KIND_GLOBAL:   w = KW_GLOBAL;
         KIND_CONST:    w = KW_CONST;
         default:       w = '0;
      endcase
      return w[8 * (3'd7 - pos) +: 8];
   endfunction

endpackage
`default_nettype wire

>>> hw/rtl/bdss_front.sv
`timescale 1ns / 1ps
`default_nettype none
module bdss_front (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_stall,
   input  wire  [7:0]             req_text_byte,
   input  wire                    req_end_of_text,
   input  wire                    q_full,
   output logic                   q_push,
   output bdss_pkg::sym_desc_type q_desc,
   output bdss_pkg::name_wr_type  name_wr
);
   import bdss_pkg::*;

   typedef enum logic [6:0] {
      PH_START   = 7'b0000001,
      PH_KEYWORD = 7'b0000010,
      PH_LABEL   = 7'b0000100,
      PH_WAIT    = 7'b0001000,
      PH_NAME    = 7'b0010000,
      PH_SKIP    = 7'b0100000,
      PH_IGNORE  = 7'b1000000
   } phase_type;

   phase_type              phase_ff, phase_in;
   kind_type               kw_ff, kw_in;
   logic [3:0]             kpos_ff, kpos_in;
   logic signed [7:0]      depth_ff, depth_in;
   logic [LEN_W-1:0]       len_ff, len_in;
   logic                   ovf_ff, ovf_in;
   logic [LINE_BITS-1:0]   line_ff, line_in;
   logic                   slot_ff, slot_in;

   logic                   accept;
   logic                   blank;
   logic [7:0]             c;
   logic [7:0]             lc;
   logic signed [7:0]      skip_src;
   logic signed [7:0]      skip_depth;
   logic                   skip_to_wait;
   logic                   skip_to_ignore;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign c         = req_text_byte;
   assign lc        = to_lower(req_text_byte);
   assign blank     = (c == CH_SPACE) || (c == CH_TAB);

   assign q_desc.kind      = kw_ff;
   assign q_desc.line      = LINE_OUT_W'(line_ff);
   assign q_desc.length    = len_ff;
   assign q_desc.truncated = ovf_ff;
   assign q_desc.slot      = slot_ff;

   // A list entry ends on the character that closes the name, which then
   // counts toward bracket nesting from a depth of zero.
   always_comb begin
      skip_src       = (phase_ff == PH_NAME) ? 8'sd0 : depth_ff;
      skip_depth     = skip_src;
      skip_to_wait   = 1'b0;
      skip_to_ignore = 1'b0;
      if (c == CH_LPAREN || c == CH_LBRACK) begin
         if (skip_src != 8'sd127) skip_depth = skip_src + 8'sd1;
      end else if (c == CH_RPAREN || c == CH_RBRACK) begin
         if (skip_src != -8'sd128) skip_depth = skip_src - 8'sd1;
      end else if (c == CH_COMMA && skip_src <= 8'sd0) begin
         skip_to_wait = 1'b1;
      end else if (c == CH_QUOTE) begin
         skip_to_ignore = 1'b1;
      end
   end

   always_comb begin
      phase_in     = phase_ff;
      kw_in        = kw_ff;
      kpos_in      = kpos_ff;
      depth_in     = depth_ff;
      len_in       = len_ff;
      ovf_in       = ovf_ff;
      line_in      = line_ff;
      slot_in      = slot_ff;
      q_push       = 1'b0;
      name_wr.en   = 1'b0;
      name_wr.addr = {slot_ff, len_ff[IDX_W-1:0]};
      name_wr.data = c;
      if (accept) begin
         if (req_end_of_text || c == CH_NL) begin
            q_push   = (phase_ff == PH_NAME);
            phase_in = PH_START;
            kw_in    = KIND_LABEL;
            kpos_in  = '0;
            depth_in = '0;
            len_in   = '0;
            ovf_in   = 1'b0;
            if (q_push) slot_in = !slot_ff;
            if (req_end_of_text) line_in = '0;
            else if (line_ff != '1) line_in = line_ff + 1'b1;
         end else begin
            unique case (phase_ff)
               PH_START: begin
                  if (c == CH_DOT) begin
                     phase_in = PH_LABEL;
                     kw_in    = KIND_LABEL;
                  end else if (!blank) begin
                     phase_in = PH_IGNORE;
                     if (lc == "f" || lc == "t" || lc == "g" || lc == "c") begin
                        phase_in = PH_KEYWORD;
                        kpos_in  = 4'd1;
                        if (lc == "f") kw_in = KIND_FUNCTION;
                        else if (lc == "t") kw_in = KIND_TYPE;
                        else if (lc == "g") kw_in = KIND_GLOBAL;
                        else kw_in = KIND_CONST;
                     end
                  end
               end
               PH_KEYWORD: begin
                  if (kpos_ff < kw_len(kw_ff)) begin
                     if (lc == kw_char(kw_ff, kpos_ff[2:0])) kpos_in = kpos_ff + 4'd1;
                     else phase_in = PH_IGNORE;
                  end else if (blank && !is_ident(c)) begin
                     phase_in = PH_WAIT;
                  end else begin
                     phase_in = PH_IGNORE;
                  end
               end
               PH_LABEL, PH_WAIT: begin
                  if (!(phase_ff == PH_WAIT && blank)) begin
                     if (is_start(c)) begin
                        name_wr.en   = 1'b1;
                        name_wr.addr = {slot_ff, IDX_W'(0)};
                        len_in       = LEN_W'(1);
                        ovf_in       = 1'b0;
                        phase_in     = PH_NAME;
                     end else begin
                        phase_in = PH_IGNORE;
                     end
                  end
               end
               PH_NAME: begin
                  if (is_ident(c)) begin
                     if (len_ff < LEN_W'(BUF_CAP)) begin
                        name_wr.en = 1'b1;
                        len_in     = len_ff + 1'b1;
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end else begin
                     q_push  = 1'b1;
                     slot_in = !slot_ff;
                     if (kw_ff == KIND_GLOBAL || kw_ff == KIND_CONST) begin
                        depth_in = skip_depth;
                        phase_in = skip_to_wait ? PH_WAIT :
                                   (skip_to_ignore ? PH_IGNORE : PH_SKIP);
                     end else begin
                        phase_in = PH_IGNORE;
                     end
                  end
               end
               PH_SKIP: begin
                  depth_in = skip_depth;
                  if (skip_to_wait) phase_in = PH_WAIT;
                  else if (skip_to_ignore) phase_in = PH_IGNORE;
               end
               PH_IGNORE: begin
                  phase_in = PH_IGNORE;
               end
               default: begin
                  phase_in = PH_START;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_START;
         kw_ff    <= KIND_LABEL;
         kpos_ff  <= '0;
         depth_ff <= '0;
         len_ff   <= '0;
         ovf_ff   <= 1'b0;
         line_ff  <= '0;
         slot_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         kw_ff    <= kw_in;
         kpos_ff  <= kpos_in;
         depth_ff <= depth_in;
         len_ff   <= len_in;
         ovf_ff   <= ovf_in;
         line_ff  <= line_in;
         slot_ff  <= slot_in;
      end
   end

endmodule
`default_nettype wire

>>> hw/rtl/bdss_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module bdss_queue (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    push,
   input  bdss_pkg::sym_desc_type push_desc,
   input  wire                    pop,
   output logic                   full,
   output logic                   head_valid,
   output bdss_pkg::sym_desc_type head_desc
);
   import bdss_pkg::*;

   // Two entries, one per name slot.
   sym_desc_type   entry_ff [2];
   logic           wr_ptr_ff, wr_ptr_in;
   logic           rd_ptr_ff, rd_ptr_in;
   logic [1:0]     count_ff, count_in;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_desc  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_desc;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

>>> hw/rtl/bdss_back.sv
`timescale 1ns / 1ps
`default_nettype none
module bdss_back (
   input  wire                    clock,
   input  wire                    reset,
   input  bdss_pkg::name_wr_type  name_wr,
   input  wire                    head_valid,
   input  bdss_pkg::sym_desc_type head_desc,
   output logic                   q_pop,
   output logic                   rsp_valid,
   input  wire                    rsp_stall,
   output logic [2:0]             rsp_symbol_kind,
   output logic [23:0]            rsp_line_number,
   output logic [7:0]             rsp_name_byte,
   output logic [4:0]             rsp_char_position,
   output logic                   rsp_name_truncated,
   output logic                   rsp_last_of_name
);
   import bdss_pkg::*;

   logic [7:0]              mem [MEM_DEPTH];
   logic [7:0]              rd_data_ff;

   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic                    pend_valid_ff, pend_valid_in;
   kind_type                pend_kind_ff;
   logic [LINE_OUT_W-1:0]   pend_line_ff;
   logic [IDX_W-1:0]        pend_pos_ff;
   logic                    pend_trunc_ff;
   logic                    pend_last_ff;
   logic                    rsp_valid_ff, rsp_valid_in;

   logic                    out_adv;
   logic                    pend_adv;
   logic                    issue;
   logic                    last;

   assign out_adv  = !rsp_valid_ff || !rsp_stall;
   assign pend_adv = pend_valid_ff && out_adv;
   assign issue    = head_valid && (!pend_valid_ff || pend_adv);
   assign last     = ({1'b0, idx_ff} == head_desc.length - LEN_W'(1));
   assign q_pop    = issue && last;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      idx_in        = q_pop ? '0 : (issue ? idx_ff + 1'b1 : idx_ff);
      pend_valid_in = issue || (pend_valid_ff && !pend_adv);
      rsp_valid_in  = pend_adv || (rsp_valid_ff && !out_adv);
   end

   always_ff @(posedge clock) begin
      if (name_wr.en) mem[name_wr.addr] <= name_wr.data;
      if (issue) begin
         rd_data_ff    <= mem[{head_desc.slot, idx_ff}];
         pend_kind_ff  <= head_desc.kind;
         pend_line_ff  <= head_desc.line;
         pend_pos_ff   <= idx_ff;
         pend_trunc_ff <= head_desc.truncated;
         pend_last_ff  <= last;
      end
      if (pend_adv) begin
         rsp_symbol_kind    <= pend_kind_ff;
         rsp_line_number    <= pend_line_ff;
         rsp_name_byte      <= rd_data_ff;
         rsp_char_position  <= pend_pos_ff;
         rsp_name_truncated <= pend_trunc_ff;
         rsp_last_of_name   <= pend_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff        <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         idx_ff        <= idx_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

>>> hw/rtl/basic_declaration_symbol_scanner_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Declaration symbol scanner. Source text enters one byte per word on the req_
// channel; a word with req_end_of_text set closes the last line and returns the
// line scan and line counter to their reset state so that a new text may follow.
// Each label, Function, Type, Global or Const name found is sent on the rsp_
// channel as one word per stored name byte, in order, with its kind, zero-based
// line, position in the name, a truncation flag and a last-byte marker.
// Throughput: one text byte per cycle in while the queue is not full, and one
// name byte per cycle out while rsp_stall is low. The scanner front end hands
// finished names to a two-entry queue backed by two name slots in a small
// memory; it stalls the input only while both slots wait to be drained. The
// first byte of a name passes through the queue, the registered memory read
// and the output register on its way to rsp_ after the word that ends the name
// is accepted. When rsp_stall is high the result word holds and draining
// pauses; input keeps being taken until both name slots are full. Reset is
// synchronous and active high; after it the block accepts input in the next
// cycle and no memory clearing pass is needed.
module basic_declaration_symbol_scanner_unit (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [7:0]  req_text_byte,
   input  wire         req_end_of_text,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [2:0]  rsp_symbol_kind,
   output logic [23:0] rsp_line_number,
   output logic [7:0]  rsp_name_byte,
   output logic [4:0]  rsp_char_position,
   output logic        rsp_name_truncated,
   output logic        rsp_last_of_name
);
   import bdss_pkg::*;

   logic          q_full;
   logic          q_push;
   logic          q_pop;
   logic          q_valid;
   sym_desc_type  push_desc;
   sym_desc_type  head_desc;
   name_wr_type   name_wr;

   // Front end: line scanning, keyword matching and name capture.
   bdss_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_text_byte   (req_text_byte),
      .req_end_of_text (req_end_of_text),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_desc          (push_desc),
      .name_wr         (name_wr)
   );

   // Finished symbols wait here; each entry owns one name slot.
   bdss_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_desc  (push_desc),
      .pop        (q_pop),
      .full       (q_full),
      .head_valid (q_valid),
      .head_desc  (head_desc)
   );

   // Back end: name memory and byte-by-byte output.
   bdss_back u_back (
      .clock              (clock),
      .reset              (reset),
      .name_wr            (name_wr),
      .head_valid         (q_valid),
      .head_desc          (head_desc),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_symbol_kind    (rsp_symbol_kind),
      .rsp_line_number    (rsp_line_number),
      .rsp_name_byte      (rsp_name_byte),
      .rsp_char_position  (rsp_char_position),
      .rsp_name_truncated (rsp_name_truncated),
      .rsp_last_of_name   (rsp_last_of_name)
   );

`ifndef ASSERT_OFF
   // A symbol is never handed over while both slots are still occupied.
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("symbol pushed into a full queue");

   // The back end only retires a symbol that is actually queued.
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("symbol retired from an empty queue");

   // Name bytes are never written into a slot that may still be draining.
   a_write_free_slot: assert property (@(posedge clock) disable iff (reset)
      name_wr.en |-> !q_full)
      else $error("name byte written while both slots are busy");
`endif

endmodule
`default_nettype wire

>>> tb/basic_declaration_symbol_scanner_unit_test.sv
`timescale 1ns / 1ps
// Self-checking bench for the declaration symbol scanner. Text bytes go in one
// word at a time on the req_ side. A predictor that runs alongside works out
// which name bytes must come out on the rsp_ side. Every accepted rsp_ word is
// checked against the oldest byte still pending.
module basic_declaration_symbol_scanner_unit_test;
   import bdss_pkg::*;

   // Where the scan of the current line stands.
   typedef enum logic [2:0] {
      PHASE_LINE_START,
      PHASE_KEYWORD,
      PHASE_LABEL,
      PHASE_AWAIT_NAME,
      PHASE_NAME,
      PHASE_SKIP_TO_COMMA,
      PHASE_IGNORE_LINE
   } scan_phase_type;

   // One name byte as the rsp_ channel must deliver it.
   typedef struct {
      kind_type                kind;
      logic [LINE_OUT_W-1:0]   line;
      logic [7:0]              name_byte;
      logic [IDX_W-1:0]        position;
      logic                    truncated;
      logic                    last_byte;
   } name_byte_type;

   // Every input is known from time zero on.
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   wire         req_stall;
   logic [7:0]  req_text_byte = 8'h00;
   logic        req_end_of_text = 1'b0;
   wire         rsp_valid;
   logic        rsp_stall = 1'b0;
   wire  [2:0]  rsp_symbol_kind;
   wire  [23:0] rsp_line_number;
   wire  [7:0]  rsp_name_byte;
   wire  [4:0]  rsp_char_position;
   wire         rsp_name_truncated;
   wire         rsp_last_of_name;

   // Predictor state. It follows the scanner one accepted word at a time.
   scan_phase_type       phase = PHASE_LINE_START;
   kind_type             decl_kind = KIND_LABEL;
   logic [3:0]           keyword_seen = '0;
   logic signed [7:0]    nesting = '0;
   logic [7:0]           name_chars [BUF_CAP];
   logic [LEN_W-1:0]     name_len = '0;
   logic                 name_cut = 1'b0;
   logic [LINE_BITS-1:0] line_no = '0;

   // Name bytes that the predictor has produced but the scanner has not yet sent.
   name_byte_type pending_name_bytes [$];

   // The text of the line that is being built, sent by flush_text.
   logic [7:0] text_q [$];

   int mismatches = 0;
   int words_sent = 0;

   // Knobs for the two sides. Some tests turn idling on or off. A hold-off
   // count makes the receiver stall without a break until it has run down.
   bit sender_idles = 1'b1;
   bit receiver_idles = 1'b1;
   int hold_off_left = 0;
   int stall_left = 0;

   basic_declaration_symbol_scanner_unit DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_text_byte      (req_text_byte),
      .req_end_of_text    (req_end_of_text),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_symbol_kind    (rsp_symbol_kind),
      .rsp_line_number    (rsp_line_number),
      .rsp_name_byte      (rsp_name_byte),
      .rsp_char_position  (rsp_char_position),
      .rsp_name_truncated (rsp_name_truncated),
      .rsp_last_of_name   (rsp_last_of_name)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // Character classes and keyword spelling.
   // ---------------------------------------------------------------------

   function automatic bit head_char(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

   function automatic bit tail_char(input logic [7:0] c);
      return head_char(c) || (c >= "0" && c <= "9") || c == CH_DOLLAR ||
             c == CH_HASH || c == CH_PERCENT;
   endfunction

   function automatic logic [7:0] fold_case(input logic [7:0] c);
      return (c >= "A" && c <= "Z") ? c + 8'h20 : c;
   endfunction

   function automatic string keyword_text(input kind_type k);
      case (k)
         KIND_FUNCTION: return "function";
         KIND_TYPE:     return "type";
         KIND_GLOBAL:   return "global";
         KIND_CONST:    return "const";
         default:       return "";
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Predictor.
   // ---------------------------------------------------------------------

   // A finished name becomes one expected word per stored byte. The line is
   // the one where the name started, and the truncation flag sits on every
   // byte of the symbol.
   function automatic void queue_name();
      name_byte_type b;
      for (int k = 0; k < name_len; k++) begin
         b.kind      = decl_kind;
         b.line      = LINE_OUT_W'(line_no);
         b.name_byte = name_chars[k];
         b.position  = IDX_W'(k);
         b.truncated = name_cut;
         b.last_byte = (k == name_len - 1);
         pending_name_bytes.insert(pending_name_bytes.size(), b);
      end
   endfunction

   // One ordinary character, not a newline. Some phases hand the character
   // on to the phase that follows in the same step. A keyword followed by its
   // delimiter is one case. A name ended by the first character of its list
   // separator is another.
   function automatic void scan_char(input logic [7:0] c);
      string kw;
      if (phase == PHASE_LINE_START) begin
         if (c == CH_SPACE || c == CH_TAB)
            return;
         if (c == CH_DOT) begin
            phase = PHASE_LABEL;
            decl_kind = KIND_LABEL;
            return;
         end
         phase = PHASE_KEYWORD;
         keyword_seen = 4'd1;
         case (fold_case(c))
            "f":     decl_kind = KIND_FUNCTION;
            "t":     decl_kind = KIND_TYPE;
            "g":     decl_kind = KIND_GLOBAL;
            "c":     decl_kind = KIND_CONST;
            default: phase = PHASE_IGNORE_LINE;
         endcase
         return;
      end
      if (phase == PHASE_KEYWORD) begin
         kw = keyword_text(decl_kind);
         if (keyword_seen < kw.len()) begin
            if (fold_case(c) == kw[keyword_seen])
               keyword_seen++;
            else
               phase = PHASE_IGNORE_LINE;
            return;
         end
         // The whole keyword has matched. An identifier character right
         // after it makes the line an ordinary one, as in "Functional".
         if (tail_char(c)) begin
            phase = PHASE_IGNORE_LINE;
            return;
         end
         phase = PHASE_AWAIT_NAME;
      end
      if (phase == PHASE_LABEL || phase == PHASE_AWAIT_NAME) begin
         if (phase == PHASE_AWAIT_NAME && (c == CH_SPACE || c == CH_TAB))
            return;
         if (head_char(c)) begin
            name_chars[0] = c;
            name_len = 1;
            name_cut = 1'b0;
            phase = PHASE_NAME;
         end else begin
            phase = PHASE_IGNORE_LINE;
         end
         return;
      end
      if (phase == PHASE_NAME) begin
         if (tail_char(c)) begin
            if (name_len < BUF_CAP) begin
               name_chars[name_len] = c;
               name_len++;
            end else begin
               name_cut = 1'b1;
            end
            return;
         end
         queue_name();
         if (decl_kind == KIND_GLOBAL || decl_kind == KIND_CONST) begin
            phase = PHASE_SKIP_TO_COMMA;
            nesting = '0;
         end else begin
            phase = PHASE_IGNORE_LINE;
            return;
         end
      end
      if (phase == PHASE_SKIP_TO_COMMA) begin
         // The bracket depth is a signed byte that sticks at its limits. A
         // comma separates names at any depth of zero or below.
         if (c == CH_LPAREN || c == CH_LBRACK) begin
            if (nesting != 8'h7F)
               nesting++;
         end else if (c == CH_RPAREN || c == CH_RBRACK) begin
            if (nesting != 8'h80)
               nesting--;
         end else if (c == CH_COMMA && nesting <= 0) begin
            phase = PHASE_AWAIT_NAME;
         end else if (c == CH_QUOTE) begin
            phase = PHASE_IGNORE_LINE;
         end
      end
   endfunction

   // A newline or the end of text closes the line. An open name is given out
   // first. The end of text also brings the line count back to zero.
   function automatic void scan_text_word(input logic [7:0] c, input logic eot);
      if (!eot && c != CH_NL) begin
         scan_char(c);
         return;
      end
      if (phase == PHASE_NAME)
         queue_name();
      phase = PHASE_LINE_START;
      decl_kind = KIND_LABEL;
      keyword_seen = '0;
      nesting = '0;
      name_len = '0;
      name_cut = 1'b0;
      if (line_no != '1)
         line_no = line_no + 1'b1;
      if (eot)
         line_no = '0;
   endfunction

   // ---------------------------------------------------------------------
   // Sending text.
   // ---------------------------------------------------------------------

   // Most words follow at once or after a short pause. Now and then a long
   // gap comes, so that the scanner is starved in every phase of its work.
   function automatic int pick_gap();
      int r = $urandom_range(0, 99);
      if (!sender_idles || r < 65)
         return 0;
      if (r < 93)
         return $urandom_range(1, 3);
      return $urandom_range(6, 30);
   endfunction

   // Offers one word and waits until the scanner takes it. Valid stays high
   // from one word to the next whenever no gap falls between them.
   task automatic send_word(input logic [7:0] b, input logic eot);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_text_byte <= b;
      req_end_of_text <= eot;
      do @(posedge clock); while (req_stall);
      words_sent++;
      scan_text_word(b, eot);
   endtask

   task automatic flush_text();
      while (text_q.size() != 0)
         send_word(text_q.pop_front(), 1'b0);
   endtask

   // The text byte of an end-of-text word means nothing, so it is random.
   task automatic send_end_of_text();
      flush_text();
      send_word(8'($urandom_range(0, 255)), 1'b1);
   endtask

   // Waits until every predicted name byte has come out.
   task automatic drain_names();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_name_bytes.size() != 0)
         @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Building text.
   // ---------------------------------------------------------------------

   // Adds one byte at the end of the line being built.
   function automatic void put_byte(input logic [7:0] c);
      text_q.insert(text_q.size(), c);
   endfunction

   function automatic void append_text(input string s);
      for (int i = 0; i < s.len(); i++)
         put_byte(s[i]);
   endfunction

   function automatic logic [7:0] random_head();
      int r = $urandom_range(0, 52);
      if (r < 26)
         return 8'("a" + r);
      if (r < 52)
         return 8'("A" + r - 26);
      return "_";
   endfunction

   function automatic logic [7:0] random_tail();
      int r = $urandom_range(0, 66);
      if (r < 53)
         return random_head();
      if (r < 63)
         return 8'("0" + r - 53);
      case (r)
         63:      return CH_DOLLAR;
         64:      return CH_HASH;
         65:      return CH_PERCENT;
         default: return "_";
      endcase
   endfunction

   function automatic logic [7:0] random_blank();
      return $urandom_range(0, 1) ? CH_SPACE : CH_TAB;
   endfunction

   // Any byte that neither continues a name nor ends the line.
   function automatic logic [7:0] random_delimiter();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255)); while (tail_char(c) || c == CH_NL);
      return c;
   endfunction

   // Names are mostly short. A few of them run past the 32 bytes that the
   // scanner keeps.
   function automatic int random_name_length();
      int r = $urandom_range(0, 99);
      if (r < 85)
         return $urandom_range(1, 8);
      if (r < 95)
         return $urandom_range(9, 31);
      return $urandom_range(32, 40);
   endfunction

   function automatic void append_name(input int n);
      put_byte(random_head());
      repeat (n - 1) put_byte(random_tail());
   endfunction

   // Keywords are matched without regard to case, so each letter gets a
   // random case.
   function automatic void append_keyword(input kind_type k);
      string kw = keyword_text(k);
      for (int i = 0; i < kw.len(); i++)
         put_byte($urandom_range(0, 1) ? kw[i] - 8'h20 : kw[i]);
   endfunction

   // A list as it follows Global or Const. A name may be followed by a
   // bracketed part with commas inside it, a stray closing bracket, or a
   // quote that ends the list.
   function automatic void append_name_list();
      int count = $urandom_range(1, 4);
      for (int i = 0; i < count; i++) begin
         append_name(random_name_length());
         case ($urandom_range(0, 7))
            0: begin
               put_byte(CH_LPAREN);
               append_name(2);
               append_text(", 7");
               put_byte(CH_RPAREN);
            end
            1: begin
               put_byte(CH_LBRACK);
               append_text("3,");
               put_byte(CH_LPAREN);
               append_text("4,5");
               put_byte(CH_RPAREN);
               put_byte(CH_RBRACK);
            end
            2: begin
               put_byte(CH_QUOTE);
               append_name(3);
            end
            3: put_byte(CH_RBRACK);
            default: ;
         endcase
         repeat ($urandom_range(0, 1)) put_byte(random_blank());
         if (i < count - 1) begin
            put_byte(CH_COMMA);
            repeat ($urandom_range(0, 2)) put_byte(random_blank());
         end
      end
   endfunction

   // Builds one random line in text_q. It returns 1 when the line is to be
   // closed by the end of text and not by a newline.
   function automatic bit compose_random_line();
      int pick = $urandom_range(0, 99);
      int cut;
      kind_type k;
      string kw;
      repeat ($urandom_range(0, 3)) put_byte(random_blank());
      if (pick < 15) begin
         put_byte(CH_DOT);
         if ($urandom_range(0, 9) == 0)
            put_byte(random_delimiter());
         append_name(random_name_length());
      end else if (pick < 40) begin
         append_keyword(pick < 30 ? KIND_FUNCTION : KIND_TYPE);
         put_byte($urandom_range(0, 3) == 0 ? random_delimiter() : random_blank());
         repeat ($urandom_range(0, 2)) put_byte(random_blank());
         append_name(random_name_length());
      end else if (pick < 70) begin
         append_keyword(pick < 55 ? KIND_GLOBAL : KIND_CONST);
         put_byte(random_blank());
         append_name_list();
      end else if (pick < 80) begin
         // Near misses: part of a keyword, a keyword run into an identifier,
         // or a name that starts with a digit.
         k = kind_type'($urandom_range(1, 4));
         kw = keyword_text(k);
         case ($urandom_range(0, 2))
            0: begin
               cut = $urandom_range(1, kw.len() - 1);
               for (int i = 0; i < cut; i++)
                  put_byte(kw[i]);
               put_byte(random_blank());
            end
            1: begin
               append_keyword(k);
               put_byte(random_tail());
               put_byte(random_blank());
            end
            default: begin
               append_keyword(k);
               put_byte(random_blank());
               put_byte(8'("0" + $urandom_range(0, 9)));
            end
         endcase
         append_name(random_name_length());
      end else begin
         repeat ($urandom_range(1, 12)) put_byte(8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 2) == 0)
         repeat ($urandom_range(1, 4)) put_byte(random_delimiter());
      pick = $urandom_range(0, 99);
      if (pick < 92) begin
         put_byte(CH_NL);
         return 1'b0;
      end
      // Otherwise the line runs on into the next one, or the text ends.
      return pick < 97;
   endfunction

   // ---------------------------------------------------------------------
   // Result checking.
   // ---------------------------------------------------------------------

   task automatic compare_field(input string field, input logic [31:0] want, got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : check_name_bytes
      name_byte_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_name_bytes.size() == 0) begin
            $error("name byte 0x%0h came out with none predicted", rsp_name_byte);
            mismatches++;
         end else begin
            want = pending_name_bytes.pop_front();
            compare_field("symbol_kind", want.kind, rsp_symbol_kind);
            compare_field("line_number", want.line, rsp_line_number);
            compare_field("name_byte", want.name_byte, rsp_name_byte);
            compare_field("char_position", want.position, rsp_char_position);
            compare_field("name_truncated", want.truncated, rsp_name_truncated);
            compare_field("last_of_name", want.last_byte, rsp_last_of_name);
         end
      end
   end

   // Receiver side. A hold-off has priority. Without one, the stall goes up
   // and down in runs of random length, most of them short. It stays low
   // while receiver idling is off.
   always @(negedge clock) begin
      if (hold_off_left > 0) begin
         rsp_stall <= 1'b1;
         hold_off_left--;
      end else if (!receiver_idles) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left--;
      end else if ($urandom_range(0, 2) == 0) begin
         rsp_stall <= 1'b1;
         stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(0, 2);
      end else begin
         rsp_stall <= 1'b0;
         stall_left = $urandom_range(0, 5);
      end
   end

   // ---------------------------------------------------------------------
   // Tests.
   // ---------------------------------------------------------------------

   // A label needs a dot at the start of the line and a name at once after
   // it. Leading blanks are skipped, and a dot later in the line means nothing.
   task automatic test_labels();
      append_text(".start\n");
      append_text("  \t.Loop_1$#%9\n");
      append_text(". gap\n");
      append_text(".9lives\n");
      append_text(".\n");
      append_text("x.notlabel\n");
      flush_text();
   endtask

   // All four keywords in mixed case. Delimiters may be blanks or other
   // characters, the keyword may be cut short or run into an identifier,
   // and the line may end right after the keyword.
   task automatic test_keywords();
      append_text("Function Draw(x)\n");
      append_text("TYPE\tPoint\n");
      append_text("fUnCtIoN(Alpha)\n");
      append_text("Functional x\n");
      append_text("Func y\n");
      append_text("type\n");
      append_text("Type 9a\n");
      append_text("typeA b\n");
      append_text("Global\n");
      append_text("const\t \tPi\n");
      flush_text();
   endtask

   // Global and Const lists. Commas in brackets are skipped, stray closing
   // brackets take the depth below zero, and a quote ends the list.
   task automatic test_lists();
      append_text("Global a, b(1,2), c[3,4] d, e 'f, g\n");
      append_text("CONST  k = 5, m=(1,(2,3)), n\n");
      append_text("const p ]], q\n");
      append_text("Global r");
      put_byte(8'h0D);
      append_text(", s\n");
      append_text("global ,t\n");
      flush_text();
   endtask

   // Bytes at the ends of the range and a carriage return act as ordinary
   // non-identifier characters.
   task automatic test_odd_bytes();
      put_byte(8'hFF);
      append_text(".x\n");
      append_text(".z");
      put_byte(8'h00);
      append_text("\n");
      append_text("Type T1");
      put_byte(8'h0D);
      append_text("\n");
      put_byte(8'h80);
      put_byte(8'h7F);
      append_text("\n.w");
      put_byte(8'hFF);
      append_text("\n");
      flush_text();
   endtask

   // Names that fill the buffer exactly, that overrun it by one byte, and
   // that overrun it by a few bytes inside a list. The list is closed by the
   // end of text.
   task automatic test_long_names();
      put_byte(CH_DOT);
      append_name(BUF_CAP);
      append_text("\n.");
      append_name(BUF_CAP + 1);
      append_text("\nGlobal ");
      append_name(BUF_CAP + 3);
      append_text(", ");
      append_name(3);
      send_end_of_text();
   endtask

   // The end of text closes an open name and sets the line count back to
   // zero. Lines that hold only a newline still count.
   task automatic test_end_of_text();
      append_text("\n\n\n.three\n");
      send_end_of_text();
      append_text(".zero\n\nConst c1, c2");
      send_end_of_text();
      send_end_of_text();
      append_text("Type back_at_zero\n");
      flush_text();
   endtask

   // The receiver holds off for a long run while the sender keeps offering
   // names with no gaps. Both name slots fill up and the scanner has to stall
   // its input until draining starts again.
   task automatic test_backpressure();
      sender_idles = 1'b0;
      hold_off_left = 300;
      for (int i = 0; i < 5; i++) begin
         if (i % 2)
            append_text("Function ");
         else
            append_text(".hold");
         append_name($urandom_range(4, 10));
         append_text("\n");
         flush_text();
      end
      sender_idles = 1'b1;
      drain_names();
   endtask

   // Random text, most of it well-formed declarations with random content.
   // Idling on each side is switched on and off from time to time.
   task automatic test_random_text();
      int stop_at = words_sent + 50;
      while (words_sent < stop_at) begin
         if ($urandom_range(0, 15) == 0) begin
            sender_idles = ($urandom_range(0, 3) != 0);
            receiver_idles = ($urandom_range(0, 3) != 0);
         end
         if (compose_random_line())
            send_end_of_text();
         else
            flush_text();
      end
      flush_text();
      sender_idles = 1'b1;
      receiver_idles = 1'b1;
   endtask

   // ---------------------------------------------------------------------
   // Run control.
   // ---------------------------------------------------------------------

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_labels();
      test_keywords();
      test_lists();
      test_odd_bytes();
      test_long_names();
      test_end_of_text();
      test_backpressure();
      test_random_text();
      drain_names();
      // Extra words may still trail behind the last expected one, so give
      // them time to show up.
      repeat (60) @(posedge clock);
      if (mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   // Watchdog. A correct run with the longest gaps and stalls ends far
   // sooner than this.
   initial begin
      #40_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule

>>> files.f
hw/rtl/bdss_pkg.sv
hw/rtl/bdss_front.sv
hw/rtl/bdss_queue.sv
hw/rtl/bdss_back.sv
hw/rtl/basic_declaration_symbol_scanner_unit.sv
tb/basic_declaration_symbol_scanner_unit_test.sv
